// File: hw/rtl/cr_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and the job record for the circle rasterizer.
package cr_pkg;

  localparam int CoordW = 15;
  localparam int PixW   = 16;
  localparam int ColorW = 32;
  localparam int DecW   = 20;
  localparam int PtIdxW = 3;
  localparam int QDepth = 2;
  localparam int QAddrW = 1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [PtIdxW-1:0] PT_LAST = 3'd7;

  localparam logic [DecW-1:0] DecInit     = 20'd3;
  localparam logic [DecW-1:0] DecStepDiag = 20'd10;
  localparam logic [DecW-1:0] DecStepAxis = 20'd6;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] ox;
    logic [CoordW-1:0] oy;
    logic [ColorW-1:0] color;
    logic              done;
  } job_t;

endpackage

// File: hw/rtl/cr_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, runs the midpoint decision update, queues point jobs.
module cr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic signed [cr_pkg::CoordW-1:0]  center_x,
  input  logic signed [cr_pkg::CoordW-1:0]  center_y,
  input  logic signed [cr_pkg::CoordW-1:0]  radius,
  input  logic        [cr_pkg::ColorW-1:0]  color,
  input  logic                              q_ready,
  output logic                              push,
  output cr_pkg::job_t                      job
);
  import cr_pkg::*;

  logic              active;
  logic [CoordW-1:0] cx_reg;
  logic [CoordW-1:0] cy_reg;
  logic [ColorW-1:0] color_reg;
  logic [CoordW-1:0] offset_x;
  logic [CoordW-1:0] offset_y;
  logic [DecW-1:0]   decision;

  logic              accept;
  logic              is_start;
  logic              r_pos;
  logic              d_pos;
  logic [CoordW-1:0] x_step;
  logic [CoordW-1:0] y_step;
  logic [DecW-1:0]   diff;
  logic [DecW-1:0]   dec_step;
  logic [DecW-1:0]   dec_start;
  logic              step_done;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign is_start = (action == ACT_START);

  always_comb begin
    r_pos     = !radius[CoordW-1] && (radius != '0);
    d_pos     = !decision[DecW-1] && (decision != '0);
    x_step    = offset_x + 1'b1;
    y_step    = d_pos ? (offset_y - 1'b1) : offset_y;
    diff      = d_pos ? ({{(DecW-CoordW){1'b0}}, x_step} - {{(DecW-CoordW){1'b0}}, y_step})
                      : {{(DecW-CoordW){1'b0}}, x_step};
    dec_step  = decision + {diff[DecW-3:0], 2'b00} + (d_pos ? DecStepDiag : DecStepAxis);
    step_done = (y_step < x_step);
    dec_start = DecInit - {{(DecW-CoordW-1){radius[CoordW-1]}}, radius, 1'b0};
  end

  always_comb begin
    push = accept && (is_start ? r_pos : active);
    if (is_start) begin
      job.cx    = center_x;
      job.cy    = center_y;
      job.ox    = '0;
      job.oy    = radius;
      job.color = color;
      job.done  = 1'b0;
    end else begin
      job.cx    = cx_reg;
      job.cy    = cy_reg;
      job.ox    = x_step;
      job.oy    = y_step;
      job.color = color_reg;
      job.done  = step_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        active <= r_pos;
      end else if (active) begin
        active <= !step_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_start) begin
        cx_reg    <= center_x;
        cy_reg    <= center_y;
        color_reg <= color;
        if (r_pos) begin
          offset_x <= '0;
          offset_y <= radius;
          decision <= dec_start;
        end
      end else if (active) begin
        offset_x <= x_step;
        offset_y <= y_step;
        decision <= dec_step;
      end
    end
  end

endmodule

// File: hw/rtl/cr_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the point emitter.
module cr_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cr_pkg::job_t job_in,
  output logic         q_ready,
  input  logic         pop,
  output logic         q_valid,
  output cr_pkg::job_t job_out
);
  import cr_pkg::*;

  job_t              entries [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QAddrW:0]   count;

  assign q_ready = (count < (QAddrW+1)'(QDepth));
  assign q_valid = (count != '0);
  assign job_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> q_ready)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QAddrW+1)'(QDepth))
    else $error("queue count out of range");

endmodule

// File: hw/rtl/cr_back.sv
`timescale 1ns / 1ps
// Back end: walks the eight mirrored points of each job into the output register.
module cr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  cr_pkg::job_t                     job,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cr_pkg::PixW-1:0]   pixel_x,
  output logic signed [cr_pkg::PixW-1:0]   pixel_y,
  output logic        [cr_pkg::ColorW-1:0] pixel_color,
  output logic                             last_of_run,
  output logic                             circle_done
);
  import cr_pkg::*;

  logic [PtIdxW-1:0] idx;
  logic              load;
  logic [PixW-1:0]   cx16;
  logic [PixW-1:0]   cy16;
  logic [PixW-1:0]   a16;
  logic [PixW-1:0]   b16;
  logic [PixW-1:0]   px;
  logic [PixW-1:0]   py;

  assign load = q_valid && (!out_valid || out_ready);
  assign pop  = load && (idx == PT_LAST);

  always_comb begin
    cx16 = {job.cx[CoordW-1], job.cx};
    cy16 = {job.cy[CoordW-1], job.cy};
    a16  = idx[2] ? {1'b0, job.oy} : {1'b0, job.ox};
    b16  = idx[2] ? {1'b0, job.ox} : {1'b0, job.oy};
    px   = idx[0] ? (cx16 - a16) : (cx16 + a16);
    py   = idx[1] ? (cy16 - b16) : (cy16 + b16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= idx + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_color <= job.color;
      last_of_run <= (idx == PT_LAST);
      circle_done <= job.done;
    end
  end

  a_last_marks_eighth: assert property (@(posedge clk) disable iff (rst)
    load |=> (last_of_run == ($past(idx) == PT_LAST)))
    else $error("last_of_run does not match point index");
  a_idx_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> idx == '0)
    else $error("point index left mid-run with empty queue");

endmodule

// File: hw/rtl/circle_rasterizer.sv
`timescale 1ns / 1ps
// Top level of the midpoint circle rasterizer.
// A start item (action 0) loads center, radius and color and yields the eight mirrored
// points of offset (0, radius); a radius of zero or less yields nothing and leaves the
// block idle. A step item (action 1) advances the offset once and yields eight points,
// all flagged circle_done on the step that closes the circle; a step while idle yields
// nothing. last_of_run marks the eighth point of each item. Coordinates are unclipped
// and wrap to 16 bits. An item that yields points sends its eight points out of the
// single point emitter, one per cycle while out_ready is high; an item that yields
// nothing never reaches the output. A two-entry job queue holds the job being emitted
// and one more, so the front end takes the next item while earlier points still go out.
module circle_rasterizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic signed [cr_pkg::CoordW-1:0] center_x,
  input  logic signed [cr_pkg::CoordW-1:0] center_y,
  input  logic signed [cr_pkg::CoordW-1:0] radius,
  input  logic        [cr_pkg::ColorW-1:0] color,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cr_pkg::PixW-1:0]   pixel_x,
  output logic signed [cr_pkg::PixW-1:0]   pixel_y,
  output logic        [cr_pkg::ColorW-1:0] pixel_color,
  output logic                             last_of_run,
  output logic                             circle_done
);
  import cr_pkg::*;

  logic q_ready;
  logic push;
  logic pop;
  logic q_valid;
  job_t job_in;
  job_t job_out;

  cr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .color    (color),
    .q_ready  (q_ready),
    .push     (push),
    .job      (job_in)
  );

  cr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .job_out (job_out)
  );

  cr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .job         (job_out),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_of_run (last_of_run),
    .circle_done (circle_done)
  );

endmodule
